// ===== hdl/epw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo pulse width package
// Shared constants, types and codes for the echo pulse width unit.
// ----------------------------------------------------------------------------
package epw_pkg;

    // Field and window sizes
    localparam int DATA_W      = 16;
    localparam int FRAC_BITS   = 8;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int WINDOW      = 10;
    localparam int TRIM_LOW    = 3;
    localparam int TRIM_COUNT  = 4;
    localparam int SUM_W       = DATA_W + $clog2(TRIM_COUNT);

    // Sort loop: the window plus one zero dummy held in the carry slot.
    // Bubble passes settle the top of the list, so only enough passes to
    // settle every rank from the trimmed low end upwards are run.
    localparam int SORT_LEN    = WINDOW + 1;
    localparam int SORT_PASSES = SORT_LEN - (TRIM_LOW + 1);

    localparam int PTR_W       = $clog2(WINDOW);
    localparam int STEP_W      = $clog2(SORT_LEN);
    localparam int PASS_W      = $clog2(SORT_PASSES);

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam logic [DATA_W-1:0] WRAP_RESET  = 16'd7999;
    localparam logic [DATA_W-1:0] SCALE_RESET = 16'd256;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [WINDOW-1:0][DATA_W-1:0] t_window;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WRAP_ADDEND = 2'd0,
        REG_SCALE_Q8    = 2'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_STORE,
        S_LOAD,
        S_SORT,
        S_EMIT
    } t_state;

    // Controls for the measurement datapath
    typedef struct packed {
        logic rise;
        logic fall;
        logic mul;
    } t_meas_ctl;

    // Controls for the shared compare-exchange loop
    typedef struct packed {
        logic load;
        logic cmp;
        logic turn;
    } t_sort_ctl;

endpackage

// ===== hdl/epw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo pulse width channel interfaces
// Capture input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface epw_cap_if import epw_pkg::*;;
    logic  valid;
    logic  ready;
    t_word capture_count;

    modport source (output valid, output capture_count, input ready);
    modport sink   (input valid, input capture_count, output ready);
endinterface

interface epw_res_if import epw_pkg::*;;
    logic  valid;
    logic  ready;
    t_word elapsed_ticks;
    t_word distance_mm;

    modport source (output valid, output elapsed_ticks, output distance_mm, input ready);
    modport sink   (input valid, input elapsed_ticks, input distance_mm, output ready);
endinterface

interface epw_cfg_if import epw_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_word                data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/epw_measure.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo pulse width measurement
// Latches the start count, forms the elapsed tick count with wrap
// correction and scales it by the Q8.8 factor with saturation.
// ----------------------------------------------------------------------------
module epw_measure import epw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_meas_ctl i_ctl,
    input  t_word     i_capture,
    input  t_word     i_wrap_addend,
    input  t_word     i_scale_q8,
    output t_word     o_ticks,
    output t_word     o_scaled
);

    t_word              r_start;
    t_word              r_ticks;
    logic [PROD_W-1:0]  r_prod;
    t_word              n_elapsed;

    // Elapsed count, adding the wrap addend when the counter rolled over
    always_comb begin
        if (i_capture < r_start) begin
            n_elapsed = i_wrap_addend + i_capture - r_start;
        end else begin
            n_elapsed = i_capture - r_start;
        end
    end

    // Hold the start count of the current pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (i_ctl.rise) begin
            r_start <= i_capture;
        end
    end

    // Capture elapsed ticks, then multiply by the scale factor
    always_ff @(posedge i_clk) begin
        if (i_ctl.fall) begin
            r_ticks <= n_elapsed;
        end
        if (i_ctl.mul) begin
            r_prod <= PROD_W'(r_ticks) * PROD_W'(i_scale_q8);
        end
    end

    // Drop the fraction and saturate to the sample width
    assign o_scaled = (|r_prod[PROD_W-1:DATA_W+FRAC_BITS])
                    ? '1 : r_prod[DATA_W+FRAC_BITS-1:FRAC_BITS];
    assign o_ticks  = r_ticks;

endmodule

// ===== hdl/epw_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo pulse width sorter
// Rotating bubble sort over a copy of the window using one shared
// compare-exchange unit, plus the mean of the middle ranks.
// ----------------------------------------------------------------------------
module epw_sorter import epw_pkg::*; (
    input  logic      i_clk,
    input  t_sort_ctl i_ctl,
    input  t_window   i_window,
    output t_word     o_mean
);

    // The list is carry followed by the buffer; carry starts as a zero dummy,
    // so buffer slot k ends up holding window rank k.
    t_word            r_carry;
    t_window          r_buf;
    t_word            w_head;
    t_word            w_lo;
    t_word            w_hi;
    t_word            n_tail;
    t_word            n_carry;
    logic [SUM_W-1:0] w_sum;

    // Shared compare-exchange unit
    assign w_head = r_buf[0];
    assign w_lo   = (r_carry > w_head) ? w_head : r_carry;
    assign w_hi   = (r_carry > w_head) ? r_carry : w_head;

    // Turn: drop the pass maximum at the tail and pick up the new list head
    assign n_tail  = i_ctl.turn ? r_carry : w_lo;
    assign n_carry = i_ctl.turn ? w_head : w_hi;

    // Load the copy, or rotate the loop by one slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_carry <= '0;
            r_buf   <= i_window;
        end else if (i_ctl.cmp || i_ctl.turn) begin
            r_carry <= n_carry;
            for (int k = 0; k < WINDOW - 1; k++) begin
                r_buf[k] <= r_buf[k+1];
            end
            r_buf[WINDOW-1] <= n_tail;
        end
    end

    // Sum the middle ranks and divide by their count
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < TRIM_COUNT; k++) begin
            w_sum = w_sum + SUM_W'(r_buf[TRIM_LOW+k]);
        end
    end

    assign o_mean = w_sum[SUM_W-1:$clog2(TRIM_COUNT)];

endmodule

// ===== hdl/echo_pulse_width_trimmed_mean_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo pulse width unit with trimmed-mean filter
// Measures echo high time from alternating edge captures, scales it to
// millimetres, keeps a ring of ten samples and emits the mean of the
// middle four ranks of the sorted window.
//
//   Port     Dir   Carries
//   i_cap    in    capture_count per echo edge
//   o_res    out   elapsed_ticks, distance_mm per falling edge
//   i_cfg    in    index, data register write (0 wrap addend, 1 scale)
//
// A rising-edge transaction only latches the start count. A falling-edge
// transaction runs through elapsed count, multiply, ring write, load, then
// 7 bubble passes through the single compare-exchange unit to its result.
// i_cap.ready is high only while idle; a pending result waits in the output
// register and the next item may be accepted meanwhile, the next result
// stalling until that one is taken. Reset is synchronous and clears the ring.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
module echo_pulse_width_trimmed_mean_unit import epw_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    epw_cap_if.sink       i_cap,
    epw_res_if.source     o_res,
    epw_cfg_if.sink       i_cfg
);

    t_state            r_state;
    t_state            n_state;
    t_word             r_wrap_addend;
    t_word             r_scale_q8;
    logic              r_await;
    t_window           r_ring;
    logic [PTR_W-1:0]  r_ptr;
    logic [STEP_W-1:0] r_step;
    logic [PASS_W-1:0] r_pass;
    logic              r_out_valid;
    t_word             r_out_ticks;
    t_word             r_out_dist;

    logic              w_cap_fire;
    logic              w_cfg_fire;
    logic              w_store;
    logic              w_emit;
    logic              w_last_step;
    t_meas_ctl         w_meas_ctl;
    t_sort_ctl         w_sort_ctl;
    t_word             w_ticks;
    t_word             w_scaled;
    t_word             w_mean;

    assign w_cap_fire  = i_cap.valid & i_cap.ready;
    assign w_cfg_fire  = i_cfg.valid & i_cfg.ready;
    assign w_last_step = (r_step == STEP_W'(WINDOW));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_cap_fire && r_await) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_STORE;
            S_STORE: n_state = S_LOAD;
            S_LOAD:  n_state = S_SORT;
            S_SORT: begin
                if (w_last_step && r_pass == PASS_W'(SORT_PASSES - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_cap.ready     = (r_state == S_IDLE);
        w_meas_ctl.rise = w_cap_fire & ~r_await;
        w_meas_ctl.fall = w_cap_fire & r_await;
        w_meas_ctl.mul  = (r_state == S_SCALE);
        w_store         = (r_state == S_STORE);
        w_sort_ctl.load = (r_state == S_LOAD);
        w_sort_ctl.cmp  = (r_state == S_SORT) & ~w_last_step;
        w_sort_ctl.turn = (r_state == S_SORT) & w_last_step;
        w_emit          = (r_state == S_EMIT) & (~r_out_valid | o_res.ready);
    end

    assign i_cfg.ready = 1'b1;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_addend <= WRAP_RESET;
            r_scale_q8    <= SCALE_RESET;
        end else if (w_cfg_fire) begin
            unique case (i_cfg.index)
                REG_WRAP_ADDEND: r_wrap_addend <= i_cfg.data;
                REG_SCALE_Q8:    r_scale_q8    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Edge phase: toggle on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b0;
        end else if (w_cap_fire) begin
            r_await <= ~r_await;
        end
    end

    // Sample ring and its write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring <= '0;
            r_ptr  <= '0;
        end else if (w_store) begin
            r_ring[r_ptr] <= w_scaled;
            r_ptr         <= (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
        end
    end

    // Sort sequencer: step within a pass, then pass count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_pass <= '0;
        end else if (w_sort_ctl.load) begin
            r_step <= '0;
            r_pass <= '0;
        end else if (w_sort_ctl.turn) begin
            r_step <= '0;
            r_pass <= r_pass + 1'b1;
        end else if (w_sort_ctl.cmp) begin
            r_step <= r_step + 1'b1;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_ticks <= w_ticks;
            r_out_dist  <= w_mean;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.elapsed_ticks = r_out_ticks;
    assign o_res.distance_mm   = r_out_dist;

    epw_measure u_measure (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_meas_ctl),
        .i_capture     (i_cap.capture_count),
        .i_wrap_addend (r_wrap_addend),
        .i_scale_q8    (r_scale_q8),
        .o_ticks       (w_ticks),
        .o_scaled      (w_scaled)
    );

    epw_sorter u_sorter (
        .i_clk    (i_clk),
        .i_ctl    (w_sort_ctl),
        .i_window (r_ring),
        .o_mean   (w_mean)
    );

    // Ring pointer stays inside the window
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr < PTR_W'(WINDOW))
        else $error("ring pointer out of range");

    // A rising edge always arms the falling-edge phase
    a_rise_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cap_fire && !r_await) |=> r_await)
        else $error("rising edge did not arm falling phase");

    // A new result appears only from the emit state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside emit");

    // Pass count never exceeds the pass budget while sorting
    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT) |-> (r_pass < PASS_W'(SORT_PASSES)))
        else $error("sort pass count out of range");

endmodule

// ===== dv/echo_distance_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo distance checker
// Watches the capture, result and configuration channels of the echo pulse
// width unit. It keeps its own copy of the edge state, the sample ring and the
// registers, works out the pulse width and trimmed-mean distance for every
// falling-edge transaction, and compares each result with the oldest one due.
// ----------------------------------------------------------------------------
module echo_distance_checker import epw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    epw_cap_if   i_cap,
    epw_res_if   i_res,
    epw_cfg_if   i_cfg,
    output int   o_mismatches,
    output int   o_outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_word elapsed_ticks;
        t_word distance_mm;
    } t_echo_result;

    t_echo_result due_results[$];

    // Mirrored registers and measurement state
    t_word wrap_addend_m;
    t_word scale_q8_m;
    logic  awaiting_fall_m;
    t_word start_count_m;
    t_word sample_ring_m [WINDOW];
    int    ring_ptr_m;
    int    mismatch_cnt;

    // Apply one capture edge; return 1 with the result on a falling edge
    function automatic bit measure_edge(input t_word cap, output t_echo_result res);
        logic [DATA_W:0]   span;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] shifted;
        t_word             ticks;
        t_word             scaled;
        t_word             sorted [WINDOW];
        t_word             tmp;
        logic [SUM_W-1:0]  sum;
        res = '0;
        if (!awaiting_fall_m) begin
            start_count_m   = cap;
            awaiting_fall_m = 1'b1;
            return 1'b0;
        end
        awaiting_fall_m = 1'b0;
        // Add the wrap addend when the counter rolled over; keep the low bits
        if (cap < start_count_m)
            span = {1'b0, wrap_addend_m} + {1'b0, cap} - {1'b0, start_count_m};
        else
            span = {1'b0, cap} - {1'b0, start_count_m};
        ticks   = span[DATA_W-1:0];
        prod    = PROD_W'(ticks) * PROD_W'(scale_q8_m);
        shifted = prod >> FRAC_BITS;
        scaled  = (shifted > PROD_W'(16'hFFFF)) ? 16'hFFFF : shifted[DATA_W-1:0];
        if (ring_ptr_m >= WINDOW)
            ring_ptr_m = 0;
        sample_ring_m[ring_ptr_m] = scaled;
        ring_ptr_m++;
        // Sort a copy, leaving the ring in write order
        sorted = sample_ring_m;
        for (int i = 0; i < WINDOW; i++) begin
            for (int j = i + 1; j < WINDOW; j++) begin
                if (sorted[i] > sorted[j]) begin
                    tmp       = sorted[i];
                    sorted[i] = sorted[j];
                    sorted[j] = tmp;
                end
            end
        end
        sum = '0;
        for (int i = TRIM_LOW; i < TRIM_LOW + TRIM_COUNT; i++)
            sum += SUM_W'(sorted[i]);
        res.elapsed_ticks = ticks;
        res.distance_mm   = t_word'(sum / TRIM_COUNT);
        return 1'b1;
    endfunction

    // Track registers, predict on capture and compare on result
    always @(posedge i_clk) begin
        t_echo_result got;
        t_echo_result want;
        t_echo_result fresh;
        if (!i_rst_n) begin
            wrap_addend_m   = WRAP_RESET;
            scale_q8_m      = SCALE_RESET;
            awaiting_fall_m = 1'b0;
            start_count_m   = '0;
            ring_ptr_m      = 0;
            for (int i = 0; i < WINDOW; i++)
                sample_ring_m[i] = '0;
            due_results.delete();
            mismatch_cnt    = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_WRAP_ADDEND: wrap_addend_m = i_cfg.data;
                    REG_SCALE_Q8:    scale_q8_m    = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                got.elapsed_ticks = i_res.elapsed_ticks;
                got.distance_mm   = i_res.distance_mm;
                if (due_results.size() == 0) begin
                    if (mismatch_cnt < REPORT_LIMIT)
                        $display("unexpected echo result: ticks %0d distance %0d",
                                 got.elapsed_ticks, got.distance_mm);
                    mismatch_cnt++;
                end else begin
                    want = due_results.pop_front();
                    if (got != want) begin
                        if (mismatch_cnt < REPORT_LIMIT)
                            $display({"echo result mismatch: expected ticks %0d distance %0d,",
                                      " got ticks %0d distance %0d"},
                                     want.elapsed_ticks, want.distance_mm,
                                     got.elapsed_ticks, got.distance_mm);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_cap.valid && i_cap.ready) begin
                if (measure_edge(i_cap.capture_count, fresh))
                    due_results.push_back(fresh);
            end
        end
        o_mismatches  <= mismatch_cnt;
        o_outstanding <= due_results.size();
    end

endmodule

// ===== dv/echo_pulse_width_trimmed_mean_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo pulse width unit test bench
// Drives echo edge captures in bursts and register settings between phases,
// stalls the result side on changing patterns with one long hold-off, and
// leaves prediction and comparison to the echo distance checker.
// ----------------------------------------------------------------------------
module echo_pulse_width_trimmed_mean_unit_test;
    import epw_pkg::*;

    localparam int  HALF_PERIOD   = 10;
    localparam int  RANDOM_PHASES = 7;
    localparam int  PULSES_PER    = 100;
    localparam int  SETTLE_CYCLES = 120;
    localparam int  HOLDOFF_LEN   = 600;
    localparam int  IDLE_LIMIT    = 5000;

    logic clk;
    logic rst_n;
    logic holdoff_req;
    int   mismatches;
    int   outstanding;
    int   idle_cycles;
    int   burst_left;

    epw_cap_if cap_if ();
    epw_res_if res_if ();
    epw_cfg_if cfg_if ();

    echo_pulse_width_trimmed_mean_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cap   (cap_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    echo_distance_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cap         (cap_if),
        .i_res         (res_if),
        .i_cfg         (cfg_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Clock
    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Offer one capture and hold it until the transaction completes
    task automatic send_capture(input t_word value);
        cap_if.valid         <= 1'b1;
        cap_if.capture_count <= value;
        do @(posedge clk); while (!cap_if.ready);
    endtask

    // Offer one capture inside the current burst, idling between bursts
    task automatic paced_capture(input t_word value);
        send_capture(value);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            cap_if.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Write both registers back to back
    task automatic write_registers(input t_word wrap, input t_word scale);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_WRAP_ADDEND;
        cfg_if.data  <= wrap;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.index <= REG_SCALE_Q8;
        cfg_if.data  <= scale;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Drop the capture valid, wait for every due result, then let the unit settle
    task automatic drain_results();
        cap_if.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: changing stall patterns and one long hold-off on request
    initial begin
        int mode;
        int mode_left;
        int tick;
        bit held;
        res_if.ready <= 1'b0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        held      = 1'b0;
        forever begin
            @(posedge clk);
            tick++;
            if (holdoff_req && !held) begin
                held = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLDOFF_LEN) @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= ($urandom_range(0, 1) == 1);
                    2:       res_if.ready <= ($urandom_range(0, 7) == 0);
                    default: res_if.ready <= ((tick % 5) != 0);
                endcase
            end
        end
    end

    // Count cycles without any transaction
    always @(posedge clk) begin
        if (!rst_n || (cap_if.valid && cap_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        t_word start;
        t_word stop;
        t_word wrap;
        t_word scale;
        burst_left           = 0;
        rst_n                <= 1'b0;
        holdoff_req          <= 1'b0;
        cap_if.valid         <= 1'b0;
        cap_if.capture_count <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= REG_WRAP_ADDEND;
        cfg_if.data          <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero width, full range, wrapped, wrap by one, small width
        send_capture(16'h0000); send_capture(16'h0000);
        send_capture(16'h0000); send_capture(16'hFFFF);
        send_capture(16'hFFFF); send_capture(16'h0000);
        send_capture(16'd1000); send_capture(16'd999);
        send_capture(16'hAAAA); send_capture(16'hAAAB);
        drain_results();

        // No wrap addend, full scale: negative gap wraps, scaled value saturates
        write_registers(16'h0000, 16'hFFFF);
        send_capture(16'd500); send_capture(16'd100);
        send_capture(16'd10);  send_capture(16'd300);
        drain_results();

        // Largest wrap addend, zero scale
        write_registers(16'hFFFF, 16'h0000);
        send_capture(16'd2); send_capture(16'd1);
        send_capture(16'h0000); send_capture(16'hFFFF);
        drain_results();

        // Smallest non-zero scale
        write_registers(WRAP_RESET, 16'd1);
        send_capture(16'd100); send_capture(16'd356);
        drain_results();

        // Random phases, each under its own register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       wrap = 16'h0000;
                1:       wrap = 16'hFFFF;
                2:       wrap = WRAP_RESET;
                default: wrap = t_word'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 4))
                0:       scale = 16'h0000;
                1:       scale = 16'hFFFF;
                2:       scale = SCALE_RESET;
                3:       scale = t_word'($urandom_range(1, 1024));
                default: scale = t_word'($urandom_range(0, 65535));
            endcase
            write_registers(wrap, scale);
            if (phase == 2)
                holdoff_req <= 1'b1;
            for (int p = 0; p < PULSES_PER; p++) begin
                start = t_word'($urandom_range(0, 65535));
                case ($urandom_range(0, 99)) inside
                    [0:39]:  stop = start + t_word'($urandom_range(0, 300));
                    [40:59]: stop = start + t_word'($urandom_range(0, 20000));
                    [60:79]: stop = t_word'($urandom_range(0, 65535));
                    [80:87]: stop = start;
                    default: stop = start - t_word'($urandom_range(1, 500));
                endcase
                paced_capture(start);
                paced_capture(stop);
                // Occasional lone edge breaks the pairing
                if ($urandom_range(0, 99) < 3)
                    paced_capture(t_word'($urandom_range(0, 65535)));
            end
            drain_results();
        end

        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
